@@ src/mlp_bp_pkg.sv @@
// Package for the 3-4-1 backpropagation trainer: sizes, codes, command struct,
// rounding helpers and the tanh lookup table built at elaboration.
// Used by mlp_bp_ctrl, mlp_bp_dp and mlp_backprop_train_step; depends on nothing.
package mlp_bp_pkg;

    localparam int INPUT_COUNT  = 3;
    localparam int HIDDEN_COUNT = 4;
    localparam int TANH_ENTRIES = 256;

    localparam int N_HW  = INPUT_COUNT * HIDDEN_COUNT;
    localparam int IN_W  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int HID_W = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int HW_W  = (N_HW > 1) ? $clog2(N_HW) : 1;
    localparam int TIDX_W = $clog2(TANH_ENTRIES);

    localparam int ONE_Q12 = 4096;
    localparam logic [12:0] RATE_HIDDEN_RESET = 13'd3277;
    localparam logic [12:0] RATE_OUTPUT_RESET = 13'd287;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TRAIN = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;
    // The spare code is handled as an evaluate.
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic CFG_RATE_HIDDEN = 1'b0;
    localparam logic CFG_RATE_OUTPUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_USE,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_HMAC,
        OP_OMAC,
        OP_OUPD1,
        OP_OUPD2,
        OP_D,
        OP_G1,
        OP_G2,
        OP_G3,
        OP_WUPD
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [HID_W-1:0] hid;
        logic [IN_W-1:0]  inp;
        logic             first;
        logic             last;
        logic             capture;
        logic             load;
        logic             mul;
        logic             use_prod;
    } cmd_t;

    typedef logic [12:0] tanh_rom_t [TANH_ENTRIES];

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        begin
            if (v > 64'sd32767)
                r = 16'sh7fff;
            else if (v < -64'sd32768)
                r = 16'sh8000;
            else
                r = 16'(v);
            return r;
        end
    endfunction

    function automatic logic signed [15:0] rnd_sat12(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = (v + 64'sd2048) >>> 12;
            return sat16(r);
        end
    endfunction

    function automatic logic signed [15:0] rnd_sat24(input logic signed [63:0] v);
        logic signed [63:0] r;
        begin
            r = (v + 64'sd8388608) >>> 24;
            return sat16(r);
        end
    endfunction

    // Restoring long division, used only while the table is built.
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q, r;
        begin
            q = 64'd0;
            r = 64'd0;
            for (int b = 63; b >= 0; b--)
            begin
                r = {r[62:0], n[b]};
                q = q << 1;
                if (r >= d)
                begin
                    r = r - d;
                    q = q | 64'd1;
                end
            end
            return q;
        end
    endfunction

    // round(4096 * tanh(xq / 4096)) by a series for exp(-2x), in Q30.
    function automatic logic [12:0] tanh_entry(input longint unsigned xq);
        longint unsigned y, n, f, en, sum, term, e, num, t, q;
        int k;
        begin
            y    = xq << 19;
            n    = y >> 30;
            f    = y & ((64'd1 << 30) - 64'd1);
            en   = 64'd1 << 30;
            sum  = 64'd1 << 30;
            term = 64'd1 << 30;
            for (k = 0; k < 16; k++)
                if (64'(k) < n)
                    en = (en * 64'd395007542) >> 30;
            for (k = 1; k <= 24; k++)
            begin
                term = udiv64((term * f) >> 30, 64'(k));
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            e = (en * sum) >> 30;
            if (e > (64'd1 << 30))
                e = 64'd1 << 30;
            num = (64'd1 << 30) - e;
            t   = udiv64(num << 30, (64'd1 << 30) + e);
            q   = (t + (64'd1 << 17)) >> 18;
            if (q > 64'd4096)
                q = 64'd4096;
            return 13'(q);
        end
    endfunction

    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t rom;
        begin
            for (int k = 0; k < TANH_ENTRIES; k++)
                rom[k] = tanh_entry(64'((longint'(k) * 32768) / TANH_ENTRIES));
            return rom;
        end
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

@@ src/mlp_bp_ctrl.sv @@
// Sequencer for the backpropagation trainer: walks the multiply steps of the
// forward pass and of the updates. Depends on mlp_bp_pkg.
module mlp_bp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic                 out_free,
    output logic                 out_load,
    output mlp_bp_pkg::cmd_t     cmd
);

    mlp_bp_pkg::state_t             state_reg, state_next;
    mlp_bp_pkg::op_t                op_reg, op_next;
    logic [mlp_bp_pkg::HID_W-1:0]   hid_reg, hid_next;
    logic [mlp_bp_pkg::IN_W-1:0]    inp_reg, inp_next;
    logic                           train_reg, train_next;
    logic                           hid_last, inp_last;

    assign hid_last = (int'(hid_reg) == mlp_bp_pkg::HIDDEN_COUNT - 1);
    assign inp_last = (int'(inp_reg) == mlp_bp_pkg::INPUT_COUNT - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlp_bp_pkg::ST_IDLE;
            op_reg    <= mlp_bp_pkg::OP_HMAC;
            hid_reg   <= '0;
            inp_reg   <= '0;
            train_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            hid_reg   <= hid_next;
            inp_reg   <= inp_next;
            train_reg <= train_next;
        end
    end

    // Next state, including the step order of the sequence.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        hid_next   = hid_reg;
        inp_next   = inp_reg;
        train_next = train_reg;
        unique case (state_reg)
            mlp_bp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    train_next = (kind == mlp_bp_pkg::KIND_TRAIN);
                    op_next    = mlp_bp_pkg::OP_HMAC;
                    hid_next   = '0;
                    inp_next   = '0;
                    state_next = (kind == mlp_bp_pkg::KIND_LOAD) ? mlp_bp_pkg::ST_LOAD
                                                                : mlp_bp_pkg::ST_MUL;
                end
            end
            mlp_bp_pkg::ST_LOAD:
                state_next = mlp_bp_pkg::ST_DONE;
            mlp_bp_pkg::ST_MUL:
                state_next = mlp_bp_pkg::ST_USE;
            mlp_bp_pkg::ST_USE:
            begin
                state_next = mlp_bp_pkg::ST_MUL;
                unique case (op_reg)
                    mlp_bp_pkg::OP_HMAC:
                    begin
                        if (inp_last)
                        begin
                            inp_next = '0;
                            if (hid_last)
                            begin
                                hid_next = '0;
                                op_next  = mlp_bp_pkg::OP_OMAC;
                            end
                            else
                                hid_next = hid_reg + 1'b1;
                        end
                        else
                            inp_next = inp_reg + 1'b1;
                    end
                    mlp_bp_pkg::OP_OMAC:
                    begin
                        if (hid_last)
                        begin
                            hid_next = '0;
                            op_next  = mlp_bp_pkg::OP_OUPD1;
                            if (!train_reg)
                                state_next = mlp_bp_pkg::ST_DONE;
                        end
                        else
                            hid_next = hid_reg + 1'b1;
                    end
                    mlp_bp_pkg::OP_OUPD1:
                        op_next = mlp_bp_pkg::OP_OUPD2;
                    mlp_bp_pkg::OP_OUPD2:
                    begin
                        if (hid_last)
                        begin
                            hid_next = '0;
                            op_next  = mlp_bp_pkg::OP_D;
                        end
                        else
                        begin
                            hid_next = hid_reg + 1'b1;
                            op_next  = mlp_bp_pkg::OP_OUPD1;
                        end
                    end
                    mlp_bp_pkg::OP_D:
                        op_next = mlp_bp_pkg::OP_G1;
                    mlp_bp_pkg::OP_G1:
                        op_next = mlp_bp_pkg::OP_G2;
                    mlp_bp_pkg::OP_G2:
                        op_next = mlp_bp_pkg::OP_G3;
                    mlp_bp_pkg::OP_G3:
                    begin
                        op_next  = mlp_bp_pkg::OP_WUPD;
                        inp_next = '0;
                    end
                    mlp_bp_pkg::OP_WUPD:
                    begin
                        if (inp_last)
                        begin
                            inp_next = '0;
                            if (hid_last)
                                state_next = mlp_bp_pkg::ST_DONE;
                            else
                            begin
                                hid_next = hid_reg + 1'b1;
                                op_next  = mlp_bp_pkg::OP_D;
                            end
                        end
                        else
                            inp_next = inp_reg + 1'b1;
                    end
                    default:
                        state_next = mlp_bp_pkg::ST_DONE;
                endcase
            end
            mlp_bp_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = mlp_bp_pkg::ST_IDLE;
            end
            default:
                state_next = mlp_bp_pkg::ST_IDLE;
        endcase
    end

    // Outputs towards the datapath and the handshake.
    always_comb
    begin
        in_ready     = 1'b0;
        out_load     = 1'b0;
        cmd.op       = op_reg;
        cmd.hid      = hid_reg;
        cmd.inp      = inp_reg;
        cmd.first    = (op_reg == mlp_bp_pkg::OP_HMAC) ? (inp_reg == '0) : (hid_reg == '0);
        cmd.last     = (op_reg == mlp_bp_pkg::OP_HMAC) ? inp_last : hid_last;
        cmd.capture  = 1'b0;
        cmd.load     = 1'b0;
        cmd.mul      = 1'b0;
        cmd.use_prod = 1'b0;
        unique case (state_reg)
            mlp_bp_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            mlp_bp_pkg::ST_LOAD:
                cmd.load = 1'b1;
            mlp_bp_pkg::ST_MUL:
                cmd.mul = 1'b1;
            mlp_bp_pkg::ST_USE:
                cmd.use_prod = 1'b1;
            mlp_bp_pkg::ST_DONE:
                out_load = out_free;
            default:
                in_ready = 1'b0;
        endcase
    end

endmodule

@@ src/mlp_bp_dp.sv @@
// Datapath of the backpropagation trainer: weight registers, one shared
// multiplier, accumulate, round and saturate, tanh lookup. Depends on mlp_bp_pkg.
module mlp_bp_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mlp_bp_pkg::cmd_t    cmd,
    input  logic signed [15:0]  x0,
    input  logic signed [15:0]  x1,
    input  logic signed [15:0]  x2,
    input  logic signed [15:0]  target,
    input  logic [3:0]          weight_slot,
    input  logic signed [15:0]  weight_value,
    input  logic [12:0]         rate_hidden,
    input  logic [12:0]         rate_output,
    output logic signed [15:0]  prediction,
    output logic signed [15:0]  error
);

    logic signed [15:0] hw_reg [mlp_bp_pkg::N_HW];
    logic signed [15:0] ow_reg [mlp_bp_pkg::HIDDEN_COUNT];
    logic signed [15:0] hv_reg [mlp_bp_pkg::HIDDEN_COUNT];
    logic signed [15:0] x_reg  [mlp_bp_pkg::INPUT_COUNT];
    logic signed [15:0] target_reg, value_reg, g_reg, pred_reg, err_reg;
    logic [3:0]         slot_reg;
    logic signed [39:0] acc_reg;
    logic signed [31:0] t_reg;
    logic signed [48:0] prod_reg;

    logic signed [15:0] x_in [mlp_bp_pkg::INPUT_COUNT];
    logic [mlp_bp_pkg::HW_W-1:0] widx;
    logic signed [31:0] op_a;
    logic signed [16:0] op_b;
    logic signed [48:0] mul;
    logic signed [39:0] acc_sum;
    logic signed [15:0] rs, ch24, hv_new;
    logic signed [16:0] s17;
    logic [16:0]        s_abs;
    logic [31:0]        tidx_wide;
    logic [mlp_bp_pkg::TIDX_W-1:0] tidx;

    always_comb
    begin
        for (int j = 0; j < mlp_bp_pkg::INPUT_COUNT; j++)
        begin
            if (j == 0)
                x_in[j] = x0;
            else if (j == 1)
                x_in[j] = x1;
            else if (j == 2)
                x_in[j] = x2;
            else
                x_in[j] = '0;
        end
    end

    assign widx = mlp_bp_pkg::HW_W'(int'(cmd.inp) * mlp_bp_pkg::HIDDEN_COUNT + int'(cmd.hid));

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (cmd.op)
            mlp_bp_pkg::OP_HMAC:
            begin
                op_a = 32'(x_reg[cmd.inp]);
                op_b = 17'(hw_reg[widx]);
            end
            mlp_bp_pkg::OP_OMAC:
            begin
                op_a = 32'(hv_reg[cmd.hid]);
                op_b = 17'(ow_reg[cmd.hid]);
            end
            mlp_bp_pkg::OP_OUPD1:
            begin
                op_a = 32'(err_reg);
                op_b = 17'(hv_reg[cmd.hid]);
            end
            mlp_bp_pkg::OP_OUPD2:
            begin
                op_a = t_reg;
                op_b = signed'({4'b0000, rate_output});
            end
            mlp_bp_pkg::OP_D:
            begin
                op_a = 32'(hv_reg[cmd.hid]);
                op_b = 17'(hv_reg[cmd.hid]);
            end
            mlp_bp_pkg::OP_G1:
            begin
                op_a = t_reg;
                op_b = 17'(ow_reg[cmd.hid]);
            end
            mlp_bp_pkg::OP_G2:
            begin
                op_a = 32'(g_reg);
                op_b = 17'(err_reg);
            end
            mlp_bp_pkg::OP_G3:
            begin
                op_a = 32'(g_reg);
                op_b = signed'({4'b0000, rate_hidden});
            end
            mlp_bp_pkg::OP_WUPD:
            begin
                op_a = 32'(g_reg);
                op_b = 17'(x_reg[cmd.inp]);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul = op_a * op_b;

    assign acc_sum = (cmd.first ? 40'sd0 : acc_reg) + 40'(prod_reg);
    assign rs = (cmd.op == mlp_bp_pkg::OP_HMAC || cmd.op == mlp_bp_pkg::OP_OMAC)
              ? mlp_bp_pkg::rnd_sat12(64'(acc_sum))
              : mlp_bp_pkg::rnd_sat12(64'(prod_reg));
    assign ch24 = mlp_bp_pkg::rnd_sat24(64'(prod_reg));

    // Tanh by table on the magnitude, sign put back afterwards.
    assign s17       = 17'(rs);
    assign s_abs     = unsigned'(s17[16] ? -s17 : s17);
    assign tidx_wide = (32'(s_abs) * 32'(mlp_bp_pkg::TANH_ENTRIES)) >> 15;
    assign tidx      = (tidx_wide > 32'(mlp_bp_pkg::TANH_ENTRIES - 1))
                     ? mlp_bp_pkg::TIDX_W'(mlp_bp_pkg::TANH_ENTRIES - 1)
                     : tidx_wide[mlp_bp_pkg::TIDX_W-1:0];
    assign hv_new    = rs[15] ? -signed'({3'b000, mlp_bp_pkg::TANH_ROM[tidx]})
                              :  signed'({3'b000, mlp_bp_pkg::TANH_ROM[tidx]});

    // Stored weights.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mlp_bp_pkg::N_HW; k++)
                hw_reg[k] <= '0;
            for (int k = 0; k < mlp_bp_pkg::HIDDEN_COUNT; k++)
                ow_reg[k] <= '0;
        end
        else if (cmd.load)
        begin
            if (int'(slot_reg) < mlp_bp_pkg::N_HW)
                hw_reg[mlp_bp_pkg::HW_W'(int'(slot_reg))] <= value_reg;
            else if (int'(slot_reg) < mlp_bp_pkg::N_HW + mlp_bp_pkg::HIDDEN_COUNT)
                ow_reg[mlp_bp_pkg::HID_W'(int'(slot_reg) - mlp_bp_pkg::N_HW)] <= value_reg;
        end
        else if (cmd.use_prod)
        begin
            if (cmd.op == mlp_bp_pkg::OP_OUPD2)
                ow_reg[cmd.hid] <= mlp_bp_pkg::sat16(64'(ow_reg[cmd.hid]) - 64'(ch24));
            else if (cmd.op == mlp_bp_pkg::OP_WUPD)
                hw_reg[widx] <= mlp_bp_pkg::sat16(64'(hw_reg[widx]) - 64'(rs));
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int j = 0; j < mlp_bp_pkg::INPUT_COUNT; j++)
                x_reg[j] <= x_in[j];
            target_reg <= target;
            slot_reg   <= weight_slot;
            value_reg  <= weight_value;
        end
        if (cmd.load)
        begin
            pred_reg <= '0;
            err_reg  <= '0;
        end
        if (cmd.mul)
            prod_reg <= mul;
        if (cmd.use_prod)
        begin
            case (cmd.op)
                mlp_bp_pkg::OP_HMAC:
                begin
                    acc_reg <= acc_sum;
                    if (cmd.last)
                        hv_reg[cmd.hid] <= hv_new;
                end
                mlp_bp_pkg::OP_OMAC:
                begin
                    acc_reg <= acc_sum;
                    if (cmd.last)
                    begin
                        pred_reg <= rs;
                        err_reg  <= mlp_bp_pkg::sat16(64'(rs) - 64'(target_reg));
                    end
                end
                mlp_bp_pkg::OP_OUPD1:
                    t_reg <= 32'(prod_reg);
                mlp_bp_pkg::OP_D:
                    t_reg <= 32'(mlp_bp_pkg::ONE_Q12) - 32'(rs);
                mlp_bp_pkg::OP_G1, mlp_bp_pkg::OP_G2, mlp_bp_pkg::OP_G3:
                    g_reg <= rs;
                default:
                    g_reg <= g_reg;
            endcase
        end
    end

    assign prediction = pred_reg;
    assign error      = err_reg;

endmodule

@@ src/mlp_backprop_train_step.sv @@
// Top level of the 3-4-1 backpropagation trainer with online gradient descent.
// Instantiates mlp_bp_ctrl and mlp_bp_dp; depends on mlp_bp_pkg.
//
// The block holds a 3-4-1 perceptron in signed Q4.12 with tanh hidden units
// (table lookup) and a linear output. Each input transaction is one of three
// kinds: a load writes one weight (slot = input*4 + hidden, then 12 + hidden
// for output weights) and returns zeros; an evaluate runs the forward pass and
// returns the prediction and the saturated error, prediction minus target; a
// train does the same and then updates the output weights and, using those
// new output weights, the input weights. Every input transaction gives exactly
// one output transaction. Items are handled one at a time. A single signed
// 32 by 17 bit multiplier does all the arithmetic, and every multiplication
// is done in an ST_MUL step (operand select and multiply) followed by an ST_USE
// step (accumulate, round and write back), so the time per item follows the
// count of multiplications. An evaluate takes 16 multiplications and a train
// 52; a load takes none. The input side is ready again as soon as the result
// sits in the output register, so the next item can start while it waits.
// The learning rates are written through cfg_we, cfg_index and cfg_data
// (index 0: rate_hidden, index 1: rate_output, both unsigned Q1.12); they
// reset to 0.8 and 0.07. They are to be written only while the block is
// idle; the user must keep to this, as the block does not enforce it.
// All weights reset to zero.
module mlp_backprop_train_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [12:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic signed [15:0]  x0,
    input  logic signed [15:0]  x1,
    input  logic signed [15:0]  x2,
    input  logic signed [15:0]  target,
    input  logic [3:0]          weight_slot,
    input  logic signed [15:0]  weight_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  prediction,
    output logic signed [15:0]  error
);

    logic [12:0]        rate_hidden_reg, rate_output_reg;
    logic               out_valid_reg;
    logic signed [15:0] prediction_reg, error_reg;
    logic               out_free, out_load;
    mlp_bp_pkg::cmd_t   cmd;
    logic signed [15:0] dp_prediction, dp_error;

    // Learning-rate registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_hidden_reg <= mlp_bp_pkg::RATE_HIDDEN_RESET;
            rate_output_reg <= mlp_bp_pkg::RATE_OUTPUT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mlp_bp_pkg::CFG_RATE_HIDDEN)
                rate_hidden_reg <= cfg_data;
            else
                rate_output_reg <= cfg_data;
        end
    end

    // The output register is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            prediction_reg <= dp_prediction;
            error_reg      <= dp_error;
        end
    end

    mlp_bp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .out_free (out_free),
        .out_load (out_load),
        .cmd      (cmd)
    );

    mlp_bp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .x0           (x0),
        .x1           (x1),
        .x2           (x2),
        .target       (target),
        .weight_slot  (weight_slot),
        .weight_value (weight_value),
        .rate_hidden  (rate_hidden_reg),
        .rate_output  (rate_output_reg),
        .prediction   (dp_prediction),
        .error        (dp_error)
    );

    assign out_valid  = out_valid_reg;
    assign prediction = prediction_reg;
    assign error      = error_reg;

endmodule
